[rtl/vrp_pkg.sv]
// ----------------------------------------------------------------------------
// vrp_pkg
// Widths, register indexes and the quarter-wave sine table for the vertex
// rotate and project pipeline.
// ----------------------------------------------------------------------------
package vrp_pkg;

    localparam int COORD_W   = 14;   // model coordinate, Q12
    localparam int TRIG_W    = 14;   // signed Q12 sine / cosine
    localparam int ANGLE_W   = 9;
    localparam int CENTER_W  = 10;
    localparam int FOCAL_W   = 11;
    localparam int ROT_W     = 16;   // rotated coordinate
    localparam int DEPTH_W   = 16;   // clamped depth, unsigned
    localparam int PROD_W    = 27;   // coordinate times focal, signed
    localparam int NUM_W     = 25;   // magnitude of that product
    localparam int QUO_W     = 13;   // quotient bits (depth >= 2^12)
    localparam int REM_W     = DEPTH_W + QUO_W;
    localparam int SCREEN_W  = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 11;

    localparam int DIV_SPS    = 2;   // divider steps per stage
    localparam int DIV_STAGES = (QUO_W + DIV_SPS - 1) / DIV_SPS;

    localparam int DEPTH_OFFSET = 16384;
    localparam int DEPTH_MIN    = 4096;
    localparam int Q_SHIFT      = 12;
    localparam int FULL_TURN    = 360;
    localparam int HALF_TURN    = 180;
    localparam int QUARTER_TURN = 90;
    localparam int FOCAL_RESET  = 100;
    localparam int ONE_Q12      = 4096;

    localparam logic [CFG_IDX_W-1:0] REG_YAW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CX    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CY    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL = 3'd4;

    typedef logic [12:0] qsin_tab_t [0:QUARTER_TURN];

    typedef struct packed {
        logic signed [TRIG_W-1:0] sin_v;
        logic signed [TRIG_W-1:0] cos_v;
    } trig_t;

    // round(4096*sin(d)) for d = 0..90 degrees
    localparam qsin_tab_t QSIN = '{
        13'd0,    13'd71,   13'd143,  13'd214,  13'd286,  13'd357,  13'd428,  13'd499,
        13'd570,  13'd641,  13'd711,  13'd782,  13'd852,  13'd921,  13'd991,  13'd1060,
        13'd1129, 13'd1198, 13'd1266, 13'd1334, 13'd1401, 13'd1468, 13'd1534, 13'd1600,
        13'd1666, 13'd1731, 13'd1796, 13'd1860, 13'd1923, 13'd1986, 13'd2048, 13'd2110,
        13'd2171, 13'd2231, 13'd2290, 13'd2349, 13'd2408, 13'd2465, 13'd2522, 13'd2578,
        13'd2633, 13'd2687, 13'd2741, 13'd2793, 13'd2845, 13'd2896, 13'd2946, 13'd2996,
        13'd3044, 13'd3091, 13'd3138, 13'd3183, 13'd3228, 13'd3271, 13'd3314, 13'd3355,
        13'd3396, 13'd3435, 13'd3474, 13'd3511, 13'd3547, 13'd3582, 13'd3617, 13'd3650,
        13'd3681, 13'd3712, 13'd3742, 13'd3770, 13'd3798, 13'd3824, 13'd3849, 13'd3873,
        13'd3896, 13'd3917, 13'd3937, 13'd3956, 13'd3974, 13'd3991, 13'd4006, 13'd4021,
        13'd4034, 13'd4046, 13'd4056, 13'd4065, 13'd4074, 13'd4080, 13'd4086, 13'd4090,
        13'd4094, 13'd4095, 13'd4096
    };

    function automatic logic [ANGLE_W-1:0] wrap_deg(input logic [ANGLE_W:0] a);
        logic [ANGLE_W:0] r;
        r = (a >= (ANGLE_W+1)'(FULL_TURN)) ? a - (ANGLE_W+1)'(FULL_TURN) : a;
        return r[ANGLE_W-1:0];
    endfunction

    // d is already below one full turn
    function automatic logic signed [TRIG_W-1:0] sin_fold(input logic [ANGLE_W-1:0] d);
        logic [ANGLE_W-1:0]    idx;
        logic                  neg;
        logic [TRIG_W-1:0]     mag;
        if (d <= ANGLE_W'(QUARTER_TURN)) begin
            idx = d;
            neg = 1'b0;
        end else if (d <= ANGLE_W'(HALF_TURN)) begin
            idx = ANGLE_W'(HALF_TURN) - d;
            neg = 1'b0;
        end else if (d <= ANGLE_W'(HALF_TURN + QUARTER_TURN)) begin
            idx = d - ANGLE_W'(HALF_TURN);
            neg = 1'b1;
        end else begin
            idx = ANGLE_W'(FULL_TURN) - d;
            neg = 1'b1;
        end
        mag = {1'b0, QSIN[idx[6:0]]};
        return neg ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic trig_t trig_lookup(input logic [ANGLE_W-1:0] a);
        trig_t              t;
        logic [ANGLE_W-1:0] d;
        d       = wrap_deg({1'b0, a});
        t.sin_v = sin_fold(d);
        t.cos_v = sin_fold(wrap_deg({1'b0, d} + (ANGLE_W+1)'(QUARTER_TURN)));
        return t;
    endfunction

endpackage

[rtl/vertex_rotate_project_unit.sv]
// ----------------------------------------------------------------------------
// vertex_rotate_project_unit
// Rotates a Q12 vertex about Y then X and projects it to screen coordinates.
// ----------------------------------------------------------------------------
// One vertex word is taken per clock while s_ready is high, and its screen word
// passes two rotation stages, a focal multiply stage, a magnitude stage, seven
// divider stages and the output register. The pipeline length is set by the 13-bit
// restoring divide by depth, done two quotient bits per stage. Stages hold
// independently, so the input keeps flowing into empty stages while a result
// waits on m_ready. Sine and cosine for an angle are looked up when its
// register is written, so words may follow a write in the next cycle.
module vertex_rotate_project_unit
    import vrp_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,

    input  logic                         cfg_we,
    input  logic [CFG_IDX_W-1:0]         cfg_addr,
    input  logic [CFG_DATA_W-1:0]        cfg_wdata,

    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [COORD_W-1:0]    s_vertex_x,
    input  logic signed [COORD_W-1:0]    s_vertex_y,
    input  logic signed [COORD_W-1:0]    s_vertex_z,
    input  logic                         s_last_vertex,

    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [SCREEN_W-1:0]   m_screen_x,
    output logic signed [SCREEN_W-1:0]   m_screen_y,
    output logic                         m_last_out
);

    localparam int NUM_ST = DIV_STAGES + 5;
    localparam int DIV0   = 3;   // valid index of the magnitude stage

    typedef struct packed {
        logic [NUM_W-1:0]   rem_x;
        logic [NUM_W-1:0]   rem_y;
        logic [QUO_W-1:0]   quo_x;
        logic [QUO_W-1:0]   quo_y;
        logic               neg_x;
        logic               neg_y;
        logic [DEPTH_W-1:0] depth;
        logic               last;
    } div_word_t;

    // ---------------- configuration ----------------
    trig_t               yaw_reg;
    trig_t               pitch_reg;
    logic [CENTER_W-1:0] cx_reg;
    logic [CENTER_W-1:0] cy_reg;
    logic [FOCAL_W-1:0]  focal_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            yaw_reg.sin_v   <= '0;
            yaw_reg.cos_v   <= TRIG_W'(ONE_Q12);
            pitch_reg.sin_v <= '0;
            pitch_reg.cos_v <= TRIG_W'(ONE_Q12);
            cx_reg          <= '0;
            cy_reg          <= '0;
            focal_reg       <= FOCAL_W'(FOCAL_RESET);
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_YAW:   yaw_reg   <= trig_lookup(cfg_wdata[ANGLE_W-1:0]);
                REG_PITCH: pitch_reg <= trig_lookup(cfg_wdata[ANGLE_W-1:0]);
                REG_CX:    cx_reg    <= cfg_wdata[CENTER_W-1:0];
                REG_CY:    cy_reg    <= cfg_wdata[CENTER_W-1:0];
                REG_FOCAL: focal_reg <= cfg_wdata[FOCAL_W-1:0];
                default:   ;
            endcase
        end
    end

    // ---------------- stage valids and enables ----------------
    logic [NUM_ST-1:0] v_reg;
    logic [NUM_ST-1:0] en;

    always_comb begin
        en[NUM_ST-1] = !v_reg[NUM_ST-1] || m_ready;
        for (int i = NUM_ST - 2; i >= 0; i--) begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign s_ready = en[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) begin
                v_reg[0] <= s_valid;
            end
            for (int i = 1; i < NUM_ST; i++) begin
                if (en[i]) begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // ---------------- stage 1: rotate about Y ----------------
    logic signed [ROT_W-1:0]   x1_reg;
    logic signed [ROT_W-1:0]   z1_reg;
    logic signed [COORD_W-1:0] y1_reg;
    logic                      last1_reg;
    logic signed [28:0]        x1_sum;
    logic signed [28:0]        z1_sum;

    always_comb begin
        x1_sum = 29'(s_vertex_x) * 29'(yaw_reg.cos_v) + 29'(s_vertex_z) * 29'(yaw_reg.sin_v);
        z1_sum = 29'(s_vertex_z) * 29'(yaw_reg.cos_v) - 29'(s_vertex_x) * 29'(yaw_reg.sin_v);
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            x1_reg    <= ROT_W'(x1_sum >>> Q_SHIFT);
            z1_reg    <= ROT_W'(z1_sum >>> Q_SHIFT);
            y1_reg    <= s_vertex_y;
            last1_reg <= s_last_vertex;
        end
    end

    // ---------------- stage 2: rotate about X ----------------
    logic signed [ROT_W-1:0] x2_reg;
    logic signed [ROT_W-1:0] y2_reg;
    logic signed [ROT_W-1:0] z2_reg;
    logic                    last2_reg;
    logic signed [31:0]      y2_sum;
    logic signed [31:0]      z2_sum;

    always_comb begin
        y2_sum = 32'(y1_reg) * 32'(pitch_reg.cos_v) - 32'(z1_reg) * 32'(pitch_reg.sin_v);
        z2_sum = 32'(y1_reg) * 32'(pitch_reg.sin_v) + 32'(z1_reg) * 32'(pitch_reg.cos_v);
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            x2_reg    <= x1_reg;
            y2_reg    <= ROT_W'(y2_sum >>> Q_SHIFT);
            z2_reg    <= ROT_W'(z2_sum >>> Q_SHIFT);
            last2_reg <= last1_reg;
        end
    end

    // ---------------- stage 3: depth and focal products ----------------
    logic signed [PROD_W-1:0]  px_reg;
    logic signed [PROD_W-1:0]  py_reg;
    logic [DEPTH_W-1:0]        depth3_reg;
    logic                      last3_reg;
    logic signed [DEPTH_W:0]   depth_raw;
    logic signed [FOCAL_W:0]   focal_s;

    always_comb begin
        depth_raw = (DEPTH_W+1)'(z2_reg) + (DEPTH_W+1)'(DEPTH_OFFSET);
        focal_s   = $signed({1'b0, focal_reg});
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            px_reg     <= PROD_W'(x2_reg) * PROD_W'(focal_s);
            py_reg     <= PROD_W'(y2_reg) * PROD_W'(focal_s);
            depth3_reg <= (depth_raw < (DEPTH_W+1)'(DEPTH_MIN)) ? DEPTH_W'(DEPTH_MIN)
                                                                : DEPTH_W'(depth_raw);
            last3_reg  <= last2_reg;
        end
    end

    // ---------------- stage 4: magnitudes for the divider ----------------
    div_word_t                div_reg [0:DIV_STAGES];
    logic signed [PROD_W-1:0] abs_x;
    logic signed [PROD_W-1:0] abs_y;

    always_comb begin
        abs_x = px_reg[PROD_W-1] ? -px_reg : px_reg;
        abs_y = py_reg[PROD_W-1] ? -py_reg : py_reg;
    end

    always_ff @(posedge aclk) begin
        if (en[DIV0]) begin
            div_reg[0].rem_x <= NUM_W'(abs_x);
            div_reg[0].rem_y <= NUM_W'(abs_y);
            div_reg[0].quo_x <= '0;
            div_reg[0].quo_y <= '0;
            div_reg[0].neg_x <= px_reg[PROD_W-1];
            div_reg[0].neg_y <= py_reg[PROD_W-1];
            div_reg[0].depth <= depth3_reg;
            div_reg[0].last  <= last3_reg;
        end
    end

    // ---------------- divider stages: restoring, MSB first ----------------
    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        div_word_t        w_next;
        logic [REM_W-1:0] shifted;

        always_comb begin
            w_next  = div_reg[k];
            shifted = '0;
            for (int j = 0; j < DIV_SPS; j++) begin
                if (k * DIV_SPS + j < QUO_W) begin
                    shifted = REM_W'(w_next.depth) << (QUO_W - 1 - (k * DIV_SPS + j));
                    if (REM_W'(w_next.rem_x) >= shifted) begin
                        w_next.rem_x = NUM_W'(REM_W'(w_next.rem_x) - shifted);
                        w_next.quo_x[QUO_W - 1 - (k * DIV_SPS + j)] = 1'b1;
                    end
                    if (REM_W'(w_next.rem_y) >= shifted) begin
                        w_next.rem_y = NUM_W'(REM_W'(w_next.rem_y) - shifted);
                        w_next.quo_y[QUO_W - 1 - (k * DIV_SPS + j)] = 1'b1;
                    end
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en[DIV0 + 1 + k]) begin
                div_reg[k+1] <= w_next;
            end
        end
    end

    // ---------------- output stage: sign and center ----------------
    logic signed [SCREEN_W-1:0] qx_s;
    logic signed [SCREEN_W-1:0] qy_s;
    logic signed [SCREEN_W-1:0] sx_reg;
    logic signed [SCREEN_W-1:0] sy_reg;
    logic                       last_reg;

    always_comb begin
        qx_s = div_reg[DIV_STAGES].neg_x ? -$signed(SCREEN_W'(div_reg[DIV_STAGES].quo_x))
                                         :  $signed(SCREEN_W'(div_reg[DIV_STAGES].quo_x));
        qy_s = div_reg[DIV_STAGES].neg_y ? -$signed(SCREEN_W'(div_reg[DIV_STAGES].quo_y))
                                         :  $signed(SCREEN_W'(div_reg[DIV_STAGES].quo_y));
    end

    always_ff @(posedge aclk) begin
        if (en[NUM_ST-1]) begin
            sx_reg   <= $signed(SCREEN_W'(cx_reg)) + qx_s;
            sy_reg   <= $signed(SCREEN_W'(cy_reg)) - qy_s;
            last_reg <= div_reg[DIV_STAGES].last;
        end
    end

    assign m_valid    = v_reg[NUM_ST-1];
    assign m_screen_x = sx_reg;
    assign m_screen_y = sy_reg;
    assign m_last_out = last_reg;

endmodule
